FILE: rtl/core/ctt_pkg.sv
// Shared types, constants and register codes for the crossing time tracker.
// No dependencies; every other file of the block refers to it by scoped names.
package ctt_pkg;

  localparam int LEVEL_BITS    = 16;
  localparam int TIME_BITS     = 32;
  localparam int COUNT_BITS    = 32;
  localparam int NUM_KINDS     = 3;
  localparam int KIND_BITS     = 2;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = (TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS;

  localparam logic [LEVEL_BITS-1:0] BITLINE_TARGET_RESET = LEVEL_BITS'(49152);
  localparam logic [LEVEL_BITS-1:0] CELL_HIGH_RESET      = LEVEL_BITS'(60948);
  localparam logic [LEVEL_BITS-1:0] CELL_LOW_RESET       = LEVEL_BITS'(4588);
  localparam logic [TIME_BITS-1:0]  SKIP_TIME_RESET      = TIME_BITS'(20000);

  typedef enum logic [KIND_BITS-1:0] {
    KIND_SENSED   = 2'd0,
    KIND_RESTORED = 2'd1,
    KIND_WRITTEN  = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FALLING_MODE   = 3'd0,
    CFG_BITLINE_TARGET = 3'd1,
    CFG_CELL_HIGH      = 3'd2,
    CFG_CELL_LOW       = 3'd3,
    CFG_SKIP_TIME      = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                  falling_mode;
    logic [LEVEL_BITS-1:0] bitline_target_level;
    logic [LEVEL_BITS-1:0] cell_high_level;
    logic [LEVEL_BITS-1:0] cell_low_level;
    logic [TIME_BITS-1:0]  skip_limit;
  } cfg_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]  sample_time;
    logic [LEVEL_BITS-1:0] bitline_level;
    logic [LEVEL_BITS-1:0] cell_level;
  } sample_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]  least;
    logic [TIME_BITS-1:0]  greatest;
    logic [COUNT_BITS-1:0] total;
  } stat_t;

endpackage

FILE: rtl/core/ctt_cfg_regs.sv
// Configuration register file of the crossing time tracker.
// Depends on ctt_pkg for the register codes, widths and reset values.
module ctt_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ctt_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [ctt_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  output ctt_pkg::cfg_t                       cfg_o
);

  ctt_pkg::cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (ctt_pkg::cfg_idx_e'(cfg_index_i))
        ctt_pkg::CFG_FALLING_MODE:   cfg_d.falling_mode = cfg_data_i[0];
        ctt_pkg::CFG_BITLINE_TARGET:
          cfg_d.bitline_target_level = cfg_data_i[ctt_pkg::LEVEL_BITS-1:0];
        ctt_pkg::CFG_CELL_HIGH:
          cfg_d.cell_high_level = cfg_data_i[ctt_pkg::LEVEL_BITS-1:0];
        ctt_pkg::CFG_CELL_LOW:
          cfg_d.cell_low_level = cfg_data_i[ctt_pkg::LEVEL_BITS-1:0];
        ctt_pkg::CFG_SKIP_TIME:
          cfg_d.skip_limit = cfg_data_i[ctt_pkg::TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.falling_mode         <= 1'b0;
      cfg_q.bitline_target_level <= ctt_pkg::BITLINE_TARGET_RESET;
      cfg_q.cell_high_level      <= ctt_pkg::CELL_HIGH_RESET;
      cfg_q.cell_low_level       <= ctt_pkg::CELL_LOW_RESET;
      cfg_q.skip_limit           <= ctt_pkg::SKIP_TIME_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: rtl/core/ctt_tracker.sv
// Crossing detector: run flags, per-kind statistics and the compare logic
// that decides which crossings one sample causes. Depends on ctt_pkg.
module ctt_tracker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  ctt_pkg::cfg_t                          cfg_i,
  input  ctt_pkg::sample_t                       sample_i,
  input  logic                                   advance_i,
  output logic [ctt_pkg::NUM_KINDS-1:0]          hit_mask_o,
  output ctt_pkg::stat_t [ctt_pkg::NUM_KINDS-1:0] stats_o
);

  logic run_idle_d, run_idle_q;
  logic sense_done_d, sense_done_q;
  logic restore_done_d, restore_done_q;
  ctt_pkg::stat_t [ctt_pkg::NUM_KINDS-1:0] stats_d, stats_q;

  logic is_start, active;
  logic hit_bitline, hit_restore, hit_write;
  logic sense_now, restore_now;
  logic [ctt_pkg::NUM_KINDS-1:0] ev;
  ctt_pkg::stat_t [ctt_pkg::NUM_KINDS-1:0] stats_new;

  always_comb begin
    is_start = (sample_i.sample_time == '0);
    active   = !is_start && !run_idle_q && (sample_i.sample_time >= cfg_i.skip_limit);

    // Falling mode swaps the sense of every compare and the two cell levels.
    if (cfg_i.falling_mode) begin
      hit_bitline = (sample_i.bitline_level <= cfg_i.bitline_target_level);
      hit_restore = (sample_i.cell_level <= cfg_i.cell_low_level);
      hit_write   = (sample_i.cell_level >= cfg_i.cell_high_level);
    end else begin
      hit_bitline = (sample_i.bitline_level >= cfg_i.bitline_target_level);
      hit_restore = (sample_i.cell_level >= cfg_i.cell_high_level);
      hit_write   = (sample_i.cell_level <= cfg_i.cell_low_level);
    end

    // Each test sees the flags left by the earlier ones on the same sample.
    ev[ctt_pkg::KIND_SENSED]   = active && !sense_done_q && hit_bitline;
    sense_now                  = sense_done_q || ev[ctt_pkg::KIND_SENSED];
    ev[ctt_pkg::KIND_RESTORED] = active && sense_now && !restore_done_q && hit_restore;
    restore_now                = restore_done_q || ev[ctt_pkg::KIND_RESTORED];
    ev[ctt_pkg::KIND_WRITTEN]  = active && restore_now && hit_write;

    for (int k = 0; k < ctt_pkg::NUM_KINDS; k++) begin
      stats_new[k].least    = (sample_i.sample_time < stats_q[k].least) ?
                              sample_i.sample_time : stats_q[k].least;
      stats_new[k].greatest = (sample_i.sample_time > stats_q[k].greatest) ?
                              sample_i.sample_time : stats_q[k].greatest;
      stats_new[k].total    = (&stats_q[k].total) ? stats_q[k].total :
                              stats_q[k].total + 1'b1;
    end

    run_idle_d     = run_idle_q;
    sense_done_d   = sense_done_q;
    restore_done_d = restore_done_q;
    stats_d        = stats_q;
    if (advance_i) begin
      if (is_start) begin
        run_idle_d     = 1'b0;
        sense_done_d   = 1'b0;
        restore_done_d = 1'b0;
      end else begin
        sense_done_d   = sense_now;
        restore_done_d = restore_now;
        run_idle_d     = run_idle_q || ev[ctt_pkg::KIND_WRITTEN];
      end
      for (int k = 0; k < ctt_pkg::NUM_KINDS; k++) begin
        if (ev[k]) begin
          stats_d[k] = stats_new[k];
        end
      end
    end
  end

  assign hit_mask_o = ev;
  assign stats_o    = stats_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_idle_q     <= 1'b1;
      sense_done_q   <= 1'b1;
      restore_done_q <= 1'b1;
      for (int k = 0; k < ctt_pkg::NUM_KINDS; k++) begin
        stats_q[k].least    <= '1;
        stats_q[k].greatest <= '0;
        stats_q[k].total    <= '0;
      end
    end else begin
      run_idle_q     <= run_idle_d;
      sense_done_q   <= sense_done_d;
      restore_done_q <= restore_done_d;
      stats_q        <= stats_d;
    end
  end

endmodule

FILE: rtl/core/ctt_result_queue.sv
// Result register holding up to three events of one sample and handing them
// out one beat at a time, lowest kind first. Depends on ctt_pkg.
module ctt_result_queue (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    load_i,
  input  logic [ctt_pkg::NUM_KINDS-1:0]           mask_i,
  input  logic [ctt_pkg::TIME_BITS-1:0]           time_i,
  input  ctt_pkg::stat_t [ctt_pkg::NUM_KINDS-1:0] stats_i,
  output logic                                    can_load_o,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [ctt_pkg::KIND_BITS-1:0]           event_kind_o,
  output logic [ctt_pkg::TIME_BITS-1:0]           event_time_o,
  output logic [ctt_pkg::TIME_BITS-1:0]           least_time_o,
  output logic [ctt_pkg::TIME_BITS-1:0]           greatest_time_o,
  output logic [ctt_pkg::COUNT_BITS-1:0]          event_total_o,
  output logic                                    last_event_o
);

  logic [ctt_pkg::NUM_KINDS-1:0] mask_d, mask_q, mask_rest;
  logic [ctt_pkg::TIME_BITS-1:0] time_q;
  ctt_pkg::stat_t [ctt_pkg::NUM_KINDS-1:0] stats_q;
  ctt_pkg::kind_e kind;
  logic beat;

  always_comb begin
    // Clearing the lowest set bit leaves the events still to go.
    mask_rest   = mask_q & (mask_q - 1'b1);
    out_valid_o = |mask_q;
    beat        = out_valid_o && !out_stall_i;
    can_load_o  = !out_valid_o || (beat && (mask_rest == '0));

    if (mask_q[ctt_pkg::KIND_SENSED]) begin
      kind = ctt_pkg::KIND_SENSED;
    end else if (mask_q[ctt_pkg::KIND_RESTORED]) begin
      kind = ctt_pkg::KIND_RESTORED;
    end else begin
      kind = ctt_pkg::KIND_WRITTEN;
    end

    mask_d = mask_q;
    if (load_i) begin
      mask_d = mask_i;
    end else if (beat) begin
      mask_d = mask_rest;
    end
  end

  assign event_kind_o    = kind;
  assign event_time_o    = time_q;
  assign least_time_o    = stats_q[kind].least;
  assign greatest_time_o = stats_q[kind].greatest;
  assign event_total_o   = stats_q[kind].total;
  assign last_event_o    = (mask_rest == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      time_q  <= time_i;
      stats_q <= stats_i;
    end
  end

endmodule

FILE: rtl/core/crossing_time_tracker.sv
// Top level of the crossing time tracker: input register, crossing detector,
// result queue and configuration registers. Depends on ctt_pkg and submodules.
//
//   channel | handshake                | payload
//   --------+--------------------------+------------------------------------------
//   in      | in_valid_i / in_stall_o  | sample_time_i, bitline_level_i, cell_level_i
//   out     | out_valid_o / out_stall_i| event_kind_o, event_time_o, least_time_o,
//           |                          | greatest_time_o, event_total_o, last_event_o
//   cfg     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// A sample beat is registered and evaluated once the result register can take its
// events, which then land there; a new sample can follow in every cycle in which
// in_stall_o is low. A sample causing n events holds the result register for n
// output beats, and the next sample is taken during the last of those beats.
// Reset leaves the tracker idle until a sample at time zero starts a run.
// Output stall backs up into in_stall_o once the result register is still busy.
module crossing_time_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ctt_pkg::TIME_BITS-1:0]       sample_time_i,
  input  logic [ctt_pkg::LEVEL_BITS-1:0]      bitline_level_i,
  input  logic [ctt_pkg::LEVEL_BITS-1:0]      cell_level_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ctt_pkg::KIND_BITS-1:0]       event_kind_o,
  output logic [ctt_pkg::TIME_BITS-1:0]       event_time_o,
  output logic [ctt_pkg::TIME_BITS-1:0]       least_time_o,
  output logic [ctt_pkg::TIME_BITS-1:0]       greatest_time_o,
  output logic [ctt_pkg::COUNT_BITS-1:0]      event_total_o,
  output logic                                last_event_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ctt_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [ctt_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);

  ctt_pkg::cfg_t    cfg;
  ctt_pkg::sample_t sample_q;
  logic in_valid_d, in_valid_q;
  logic accept, advance, can_load;
  logic [ctt_pkg::NUM_KINDS-1:0] hit_mask;
  ctt_pkg::stat_t [ctt_pkg::NUM_KINDS-1:0] stats;

  assign advance    = in_valid_q && can_load;
  assign in_stall_o = in_valid_q && !can_load;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q.sample_time   <= sample_time_i;
      sample_q.bitline_level <= bitline_level_i;
      sample_q.cell_level    <= cell_level_i;
    end
  end

  ctt_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ctt_tracker u_tracker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .sample_i   (sample_q),
    .advance_i  (advance),
    .hit_mask_o (hit_mask),
    .stats_o    (stats)
  );

  ctt_result_queue u_result_queue (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (advance),
    .mask_i          (hit_mask),
    .time_i          (sample_q.sample_time),
    .stats_i         (stats),
    .can_load_o      (can_load),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_kind_o    (event_kind_o),
    .event_time_o    (event_time_o),
    .least_time_o    (least_time_o),
    .greatest_time_o (greatest_time_o),
    .event_total_o   (event_total_o),
    .last_event_o    (last_event_o)
  );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for crossing_time_tracker: drives sample and register beats,
// predicts every crossing event and compares each result beat field by field.
// Depends on ctt_pkg and the RTL of the block.
module tb_top;

  typedef struct {
    ctt_pkg::kind_e                 kind;
    logic [ctt_pkg::TIME_BITS-1:0]  at;
    logic [ctt_pkg::TIME_BITS-1:0]  least;
    logic [ctt_pkg::TIME_BITS-1:0]  greatest;
    logic [ctt_pkg::COUNT_BITS-1:0] total;
    logic                           last;
  } crossing_t;

  logic                              clk           = 1'b0;
  logic                              rst_n         = 1'b0;
  logic                              in_valid      = 1'b0;
  logic                              in_stall;
  logic [ctt_pkg::TIME_BITS-1:0]     sample_time   = '0;
  logic [ctt_pkg::LEVEL_BITS-1:0]    bitline_level = '0;
  logic [ctt_pkg::LEVEL_BITS-1:0]    cell_level    = '0;
  logic                              out_valid;
  logic                              out_stall     = 1'b0;
  logic [ctt_pkg::KIND_BITS-1:0]     event_kind;
  logic [ctt_pkg::TIME_BITS-1:0]     event_time;
  logic [ctt_pkg::TIME_BITS-1:0]     least_time;
  logic [ctt_pkg::TIME_BITS-1:0]     greatest_time;
  logic [ctt_pkg::COUNT_BITS-1:0]    event_total;
  logic                              last_event;
  logic                              cfg_valid     = 1'b0;
  logic                              cfg_ready;
  logic [ctt_pkg::CFG_IDX_BITS-1:0]  cfg_index     = '0;
  logic [ctt_pkg::CFG_DATA_BITS-1:0] cfg_data      = '0;

  // Shadow copy of the tracker: configuration, run flags and per-kind statistics.
  ctt_pkg::cfg_t                  model_cfg;
  bit                             run_idle_q;
  bit                             sensed_q;
  bit                             restored_q;
  logic [ctt_pkg::TIME_BITS-1:0]  least_q    [ctt_pkg::NUM_KINDS];
  logic [ctt_pkg::TIME_BITS-1:0]  greatest_q [ctt_pkg::NUM_KINDS];
  logic [ctt_pkg::COUNT_BITS-1:0] total_q    [ctt_pkg::NUM_KINDS];
  crossing_t                      expected_events [$];

  int          error_count    = 0;
  int unsigned source_max_gap = 10;
  int unsigned sink_max_gap   = 10;
  int unsigned sink_wait_left = 0;
  int unsigned sink_hold_left = 0;

  crossing_time_tracker dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .sample_time_i   (sample_time),
    .bitline_level_i (bitline_level),
    .cell_level_i    (cell_level),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .event_kind_o    (event_kind),
    .event_time_o    (event_time),
    .least_time_o    (least_time),
    .greatest_time_o (greatest_time),
    .event_total_o   (event_total),
    .last_event_o    (last_event),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void reset_model();
    model_cfg.falling_mode         = 1'b0;
    model_cfg.bitline_target_level = ctt_pkg::BITLINE_TARGET_RESET;
    model_cfg.cell_high_level      = ctt_pkg::CELL_HIGH_RESET;
    model_cfg.cell_low_level       = ctt_pkg::CELL_LOW_RESET;
    model_cfg.skip_limit           = ctt_pkg::SKIP_TIME_RESET;
    run_idle_q = 1'b1;
    sensed_q   = 1'b1;
    restored_q = 1'b1;
    for (int k = 0; k < ctt_pkg::NUM_KINDS; k++) begin
      least_q[k]    = '1;
      greatest_q[k] = '0;
      total_q[k]    = '0;
    end
  endfunction

  function automatic void apply_register(logic [ctt_pkg::CFG_IDX_BITS-1:0] idx,
                                         logic [ctt_pkg::CFG_DATA_BITS-1:0] data);
    case (idx)
      ctt_pkg::CFG_FALLING_MODE:
        model_cfg.falling_mode = data[0];
      ctt_pkg::CFG_BITLINE_TARGET:
        model_cfg.bitline_target_level = data[ctt_pkg::LEVEL_BITS-1:0];
      ctt_pkg::CFG_CELL_HIGH:
        model_cfg.cell_high_level = data[ctt_pkg::LEVEL_BITS-1:0];
      ctt_pkg::CFG_CELL_LOW:
        model_cfg.cell_low_level = data[ctt_pkg::LEVEL_BITS-1:0];
      ctt_pkg::CFG_SKIP_TIME:
        model_cfg.skip_limit = data[ctt_pkg::TIME_BITS-1:0];
      default: ;
    endcase
  endfunction

  function automatic void record_crossing(ctt_pkg::kind_e kind,
                                          logic [ctt_pkg::TIME_BITS-1:0] at);
    crossing_t ev;
    if (at < least_q[kind]) least_q[kind] = at;
    if (at > greatest_q[kind]) greatest_q[kind] = at;
    if (total_q[kind] != '1) total_q[kind] = total_q[kind] + 1'b1;
    ev.kind     = kind;
    ev.at       = at;
    ev.least    = least_q[kind];
    ev.greatest = greatest_q[kind];
    ev.total    = total_q[kind];
    ev.last     = 1'b0;
    expected_events = {expected_events, ev};
  endfunction

  function automatic void predict_crossings(logic [ctt_pkg::TIME_BITS-1:0] t,
                                            logic [ctt_pkg::LEVEL_BITS-1:0] bl,
                                            logic [ctt_pkg::LEVEL_BITS-1:0] cell_lvl);
    int unsigned queued;
    bit          hit;
    if (t == '0) begin
      run_idle_q = 1'b0;
      sensed_q   = 1'b0;
      restored_q = 1'b0;
      return;
    end
    if (run_idle_q || t < model_cfg.skip_limit) return;
    queued = expected_events.size();
    // Each test sees the flags left by the one before it on the same sample.
    hit = model_cfg.falling_mode ? (bl <= model_cfg.bitline_target_level)
                                 : (bl >= model_cfg.bitline_target_level);
    if (!sensed_q && hit) begin
      record_crossing(ctt_pkg::KIND_SENSED, t);
      sensed_q = 1'b1;
    end
    hit = model_cfg.falling_mode ? (cell_lvl <= model_cfg.cell_low_level)
                                 : (cell_lvl >= model_cfg.cell_high_level);
    if (sensed_q && !restored_q && hit) begin
      record_crossing(ctt_pkg::KIND_RESTORED, t);
      restored_q = 1'b1;
    end
    hit = model_cfg.falling_mode ? (cell_lvl >= model_cfg.cell_high_level)
                                 : (cell_lvl <= model_cfg.cell_low_level);
    if (restored_q && hit) begin
      record_crossing(ctt_pkg::KIND_WRITTEN, t);
      run_idle_q = 1'b1;
    end
    if (expected_events.size() > queued)
      expected_events[expected_events.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [63:0] expected, logic [63:0] actual);
    if (expected !== actual) begin
      $error("%s mismatch: expected %0h, got %0h", name, expected, actual);
      error_count++;
    end
  endfunction

  // Result sink: the stall pattern is counted down here, one cycle at a time.
  initial begin
    forever begin
      @(negedge clk);
      if (sink_hold_left > 0) begin
        out_stall <= 1'b1;
        sink_hold_left--;
      end else if (sink_wait_left > 0) begin
        out_stall <= 1'b1;
        sink_wait_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    crossing_t exp_ev;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sink_wait_left = $urandom_range(0, sink_max_gap);
        if (expected_events.size() == 0) begin
          $error("event beat with nothing expected: kind %0d, time %0h",
                 event_kind, event_time);
          error_count++;
        end else begin
          exp_ev = expected_events.pop_front();
          check_field("event_kind", 64'(exp_ev.kind), 64'(event_kind));
          check_field("event_time", 64'(exp_ev.at), 64'(event_time));
          check_field("least_time", 64'(exp_ev.least), 64'(least_time));
          check_field("greatest_time", 64'(exp_ev.greatest), 64'(greatest_time));
          check_field("event_total", 64'(exp_ev.total), 64'(event_total));
          check_field("last_event", 64'(exp_ev.last), 64'(last_event));
        end
      end
    end
  end

  task automatic send_sample(logic [ctt_pkg::TIME_BITS-1:0] t,
                             logic [ctt_pkg::LEVEL_BITS-1:0] bl,
                             logic [ctt_pkg::LEVEL_BITS-1:0] cell_lvl);
    int unsigned gap;
    gap = $urandom_range(0, source_max_gap);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    sample_time   <= t;
    bitline_level <= bl;
    cell_level    <= cell_lvl;
    do @(posedge clk); while (in_stall);
    predict_crossings(t, bl, cell_lvl);
  endtask

  task automatic write_register(logic [ctt_pkg::CFG_IDX_BITS-1:0] idx,
                                logic [ctt_pkg::CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_config(logic fall, logic [ctt_pkg::LEVEL_BITS-1:0] target,
                             logic [ctt_pkg::LEVEL_BITS-1:0] high,
                             logic [ctt_pkg::LEVEL_BITS-1:0] low,
                             logic [ctt_pkg::TIME_BITS-1:0] skip);
    write_register(ctt_pkg::CFG_FALLING_MODE, ctt_pkg::CFG_DATA_BITS'(fall));
    write_register(ctt_pkg::CFG_BITLINE_TARGET, ctt_pkg::CFG_DATA_BITS'(target));
    write_register(ctt_pkg::CFG_CELL_HIGH, ctt_pkg::CFG_DATA_BITS'(high));
    write_register(ctt_pkg::CFG_CELL_LOW, ctt_pkg::CFG_DATA_BITS'(low));
    write_register(ctt_pkg::CFG_SKIP_TIME, ctt_pkg::CFG_DATA_BITS'(skip));
  endtask

  // Samples that cause no event may still be in flight, so the task keeps waiting after
  // the last event beat before the block counts as idle.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [ctt_pkg::LEVEL_BITS-1:0] near_level(
      logic [ctt_pkg::LEVEL_BITS-1:0] thr);
    case ($urandom_range(0, 3))
      0:       return ctt_pkg::LEVEL_BITS'($urandom);
      1:       return $urandom_range(0, 1) ? {ctt_pkg::LEVEL_BITS{1'b1}}
                                           : {ctt_pkg::LEVEL_BITS{1'b0}};
      default: return thr + ctt_pkg::LEVEL_BITS'($urandom_range(0, 16))
                       - ctt_pkg::LEVEL_BITS'(8);
    endcase
  endfunction

  task automatic randomize_config();
    logic [ctt_pkg::LEVEL_BITS-1:0] target;
    logic [ctt_pkg::LEVEL_BITS-1:0] high;
    logic [ctt_pkg::LEVEL_BITS-1:0] low;
    logic [ctt_pkg::TIME_BITS-1:0]  skip;
    target = near_level(ctt_pkg::LEVEL_BITS'($urandom));
    if ($urandom_range(0, 3) == 0) begin
      high = near_level(ctt_pkg::LEVEL_BITS'($urandom));
      low  = near_level(ctt_pkg::LEVEL_BITS'($urandom));
    end else begin
      high = ctt_pkg::LEVEL_BITS'($urandom_range(16'h8000, 16'hFFFF));
      low  = ctt_pkg::LEVEL_BITS'($urandom_range(16'h0000, 16'h7FFF));
    end
    case ($urandom_range(0, 7))
      0:       skip = '0;
      1:       skip = '1;
      default: skip = ctt_pkg::TIME_BITS'($urandom_range(0, 50000));
    endcase
    load_config(1'($urandom_range(0, 1)), target, high, low, skip);
  endtask

  // One run start followed by samples mostly inside the window and near the thresholds.
  task automatic run_random_sequence(int unsigned steps);
    logic [ctt_pkg::TIME_BITS-1:0]  t;
    logic [ctt_pkg::LEVEL_BITS-1:0] cell_thr;
    send_sample('0, ctt_pkg::LEVEL_BITS'($urandom), ctt_pkg::LEVEL_BITS'($urandom));
    repeat (steps) begin
      case ($urandom_range(0, 19))
        0: send_sample('0, ctt_pkg::LEVEL_BITS'($urandom), ctt_pkg::LEVEL_BITS'($urandom));
        1, 2: begin
          t = (model_cfg.skip_limit == '0) ? '0
                                           : $urandom_range(0, model_cfg.skip_limit - 1);
          send_sample(t, near_level(model_cfg.bitline_target_level),
                      near_level(model_cfg.cell_high_level));
        end
        3: send_sample($urandom, ctt_pkg::LEVEL_BITS'($urandom),
                       ctt_pkg::LEVEL_BITS'($urandom));
        default: begin
          t        = $urandom_range(model_cfg.skip_limit, {ctt_pkg::TIME_BITS{1'b1}});
          cell_thr = $urandom_range(0, 1) ? model_cfg.cell_high_level
                                          : model_cfg.cell_low_level;
          send_sample(t, near_level(model_cfg.bitline_target_level), near_level(cell_thr));
        end
      endcase
    end
  endtask

  task automatic test_default_run();
    send_sample(32'd30000, 16'hFFFF, 16'hFFFF);   // idle after reset
    send_sample('0, 16'h0000, 16'h0000);
    send_sample(32'd100, 16'hFFFF, 16'hFFFF);     // before the skip time
    send_sample(32'd25000, 16'h1000, 16'hFFFF);
    send_sample(32'd26000, 16'hFFFF, 16'h8000);
    send_sample(32'd27000, 16'hFFFF, 16'hFFFF);
    send_sample(32'd28000, 16'h0000, 16'h0000);
    send_sample(32'd29000, 16'hFFFF, 16'hFFFF);   // run already ended
  endtask

  task automatic test_all_at_once();
    drain_results();
    // With the high level below the low level one cell value hits all three tests.
    load_config(1'b0, 16'h8000, 16'h1000, 16'h2000, 32'd20000);
    send_sample('0, 16'h0000, 16'h0000);
    send_sample(32'd25000, 16'h9000, 16'h1800);
    drain_results();
    write_register(ctt_pkg::CFG_FALLING_MODE, ctt_pkg::CFG_DATA_BITS'(1'b1));
    send_sample('0, 16'hFFFF, 16'hFFFF);
    send_sample(32'd21000, 16'h7000, 16'h1800);
  endtask

  task automatic test_falling_run();
    drain_results();
    load_config(1'b1, 16'h4000, 16'hEE14, 16'h11EC, 32'd20000);
    send_sample('0, 16'hFFFF, 16'hFFFF);
    send_sample(32'd30000, 16'h7530, 16'h8000);
    send_sample(32'd31000, 16'h2710, 16'h0FA0);
    send_sample(32'd32000, 16'h0000, 16'hF230);
  endtask

  task automatic test_extreme_levels();
    drain_results();
    load_config(1'b0, 16'hFFFF, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
    send_sample('0, 16'h0000, 16'h0000);
    send_sample(32'hFFFF_FFFE, 16'hFFFF, 16'hFFFF);
    send_sample(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_sample(32'hFFFF_FFFF, 16'h0000, 16'h0000);
    drain_results();
    load_config(1'b0, 16'h0000, 16'h0000, 16'h0000, 32'd0);
    send_sample('0, 16'hFFFF, 16'hFFFF);
    send_sample(32'd1, 16'h0000, 16'h0000);
  endtask

  task automatic test_register_masking();
    drain_results();
    // Data bits above each register's width must be dropped.
    write_register(ctt_pkg::CFG_FALLING_MODE, 32'hFFFF_FFFE);
    write_register(ctt_pkg::CFG_BITLINE_TARGET, 32'hABCD_9000);
    write_register(ctt_pkg::CFG_CELL_HIGH, 32'h5555_F000);
    write_register(ctt_pkg::CFG_CELL_LOW, 32'hAAAA_0800);
    write_register(ctt_pkg::CFG_SKIP_TIME, 32'd5000);
    for (int k = ctt_pkg::CFG_SKIP_TIME + 1; k < 2 ** ctt_pkg::CFG_IDX_BITS; k++)
      write_register(ctt_pkg::CFG_IDX_BITS'(k), $urandom);
    send_sample('0, 16'h0000, 16'h0000);
    send_sample(32'd6000, 16'hFFFF, 16'hFFFF);
    send_sample(32'd7000, 16'h0000, 16'h0000);
  endtask

  task automatic test_random_phases(int unsigned phases, int unsigned steps);
    repeat (phases) begin
      drain_results();
      randomize_config();
      repeat (2) run_random_sequence(steps);
    end
  endtask

  task automatic test_no_idling();
    source_max_gap = 0;
    sink_max_gap   = 0;
    test_random_phases(1, 7);
    drain_results();
    source_max_gap = 10;
    sink_max_gap   = 10;
  endtask

  task automatic test_backpressure();
    drain_results();
    load_config(1'b0, 16'h8000, 16'h1000, 16'h2000, 32'd100);
    sink_hold_left = 300;
    source_max_gap = 0;
    repeat (12) begin
      send_sample('0, 16'h0000, 16'h0000);
      send_sample($urandom_range(100, 32'hFFFF_FFFF), 16'hFFFF, 16'h1800);
    end
    source_max_gap = 10;
    drain_results();
  endtask

  initial begin
    reset_model();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_default_run();
    test_all_at_once();
    test_falling_run();
    test_extreme_levels();
    test_register_masking();
    test_random_phases(7, 7);
    test_no_idling();
    test_backpressure();

    drain_results();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/ctt_pkg.sv
rtl/core/ctt_cfg_regs.sv
rtl/core/ctt_tracker.sv
rtl/core/ctt_result_queue.sv
rtl/core/crossing_time_tracker.sv
test/tb_top.sv
